// ===== hw/rtl/pli_pkg.sv =====
package pli_pkg;

    localparam int CAPACITY = 64;
    localparam int INDEX_W  = 7;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = $clog2(CAPACITY);

    // The removed byte is picked through a two-level registered select tree.
    localparam int LSB_W    = POS_W / 2;
    localparam int GROUP    = 1 << LSB_W;
    localparam int NGROUP   = CAPACITY / GROUP;
    localparam int MSB_W    = (NGROUP > 1) ? $clog2(NGROUP) : 1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef struct packed {
        logic load;
        logic exec;
        logic fin;
    } ctrl_t;

endpackage

// ===== hw/rtl/pli_ctrl.sv =====
module pli_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output pli_pkg::ctrl_t ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   load;

    // A new command is taken in the idle state and also while the previous
    // result is being finished.
    assign load = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = load ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next == ST_EXEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy      = busy_reg;
    assign ctrl.load = load;
    assign ctrl.exec = (state_reg == ST_EXEC);
    assign ctrl.fin  = (state_reg == ST_FIN);

    a_busy_exec: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg == ST_EXEC))
        else $error("busy does not match the execute state");

    a_exec_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> (state_reg == ST_FIN))
        else $error("execute state not followed by finish state");

    a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (state_reg == ST_EXEC))
        else $error("accepted command did not enter execute state");

endmodule

// ===== hw/rtl/pli_dp.sv =====
module pli_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pli_pkg::ctrl_t                ctrl,
    input  logic                          cmd,
    input  logic [pli_pkg::INDEX_W-1:0]   index,
    input  logic [pli_pkg::BYTE_W-1:0]    byte_in,
    output logic                          done,
    output logic                          ok,
    output logic [pli_pkg::BYTE_W-1:0]    removed_byte,
    output logic [pli_pkg::CNT_W-1:0]     count
);

    localparam int CAP   = pli_pkg::CAPACITY;
    localparam int CW    = pli_pkg::CNT_W;
    localparam int BW    = pli_pkg::BYTE_W;
    localparam int IW    = pli_pkg::INDEX_W;
    localparam int LW    = pli_pkg::LSB_W;
    localparam int GRP   = pli_pkg::GROUP;
    localparam int NGRP  = pli_pkg::NGROUP;
    localparam int MW    = pli_pkg::MSB_W;
    localparam int PW    = pli_pkg::POS_W;

    logic          cmd_reg;
    logic [IW-1:0] idx_reg;
    logic [BW-1:0] byte_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [BW-1:0] entries_reg [CAP];
    logic [BW-1:0] entries_next [CAP];
    logic [BW-1:0] group_reg [NGRP];
    logic [MW-1:0] hi_sel_reg;
    logic          ok_pend_reg;
    logic          del_pend_reg;
    logic          done_reg;
    logic          ok_reg;
    logic [BW-1:0] removed_reg;
    logic [CW-1:0] count_out_reg;

    logic          ins_ok;
    logic          del_ok;
    logic [CW-1:0] idx_ext;
    logic [LW-1:0] lo_sel;
    logic [MW-1:0] hi_sel;

    assign idx_ext = CW'(idx_reg);
    assign ins_ok  = (cmd_reg == pli_pkg::CMD_INSERT) && (count_reg < CW'(CAP))
                     && (idx_ext <= count_reg);
    assign del_ok  = (cmd_reg == pli_pkg::CMD_DELETE) && (idx_ext < count_reg);
    assign lo_sel  = idx_reg[LW-1:0];

    generate
        if (NGRP > 1)
        begin : g_hi
            assign hi_sel = idx_reg[PW-1:LW];
        end
        else
        begin : g_hi_one
            assign hi_sel = '0;
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Each cell looks only at itself and its two neighbors.
    generate
        for (genvar i = 0; i < CAP; i++)
        begin : g_cell
            localparam logic [CW-1:0] POS = CW'(i);
            logic [BW-1:0] left_val;
            logic [BW-1:0] right_val;

            if (i > 0)
            begin : g_left
                assign left_val = entries_reg[i-1];
            end
            else
            begin : g_left_none
                assign left_val = entries_reg[i];
            end

            if (i < CAP - 1)
            begin : g_right
                assign right_val = entries_reg[i+1];
            end
            else
            begin : g_right_none
                assign right_val = entries_reg[i];
            end

            always_comb
            begin
                entries_next[i] = entries_reg[i];
                if (ins_ok)
                begin
                    if (POS == idx_ext)
                    begin
                        entries_next[i] = byte_reg;
                    end
                    else if (POS > idx_ext)
                    begin
                        entries_next[i] = left_val;
                    end
                end
                else if (del_ok)
                begin
                    if (POS >= idx_ext)
                    begin
                        entries_next[i] = right_val;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.exec)
            begin
                count_reg <= count_next;
            end
            done_reg <= ctrl.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= cmd;
            idx_reg  <= index;
            byte_reg <= byte_in;
        end
        if (ctrl.exec)
        begin
            for (int i = 0; i < CAP; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
            // First level of the select tree, taken from the contents before
            // the shift.
            for (int g = 0; g < NGRP; g++)
            begin
                group_reg[g] <= entries_reg[g * GRP + int'(lo_sel)];
            end
            hi_sel_reg   <= hi_sel;
            ok_pend_reg  <= ins_ok || del_ok;
            del_pend_reg <= del_ok;
        end
        if (ctrl.fin)
        begin
            ok_reg        <= ok_pend_reg;
            removed_reg   <= del_pend_reg ? group_reg[hi_sel_reg] : '0;
            count_out_reg <= count_reg;
        end
    end

    assign done         = done_reg;
    assign ok           = ok_reg;
    assign removed_byte = removed_reg;
    assign count        = count_out_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAP))
        else $error("entry count above capacity");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.exec && ins_ok) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not raise the count by one");

    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.exec && del_ok) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("delete did not lower the count by one");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !ok_reg) |-> (removed_reg == '0))
        else $error("rejected command reports a removed byte");

endmodule

// ===== hw/rtl/positional_list_insert_delete.sv =====
// A command is captured when it is accepted and applied in the execute state;
// its result is registered in the finish state and shown with done high for one cycle.
// A new command can be accepted in the finish state; busy is high only in the execute
// state, when all 64 entry registers shift in parallel.
// Reset (rst_n low, asynchronous) empties the list; entry contents are not cleared.
// The receiver cannot stall: done is high for exactly one cycle per result.
module positional_list_insert_delete
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic [pli_pkg::INDEX_W-1:0] index,
    input  logic [pli_pkg::BYTE_W-1:0]  byte_in,
    output logic                        done,
    output logic                        ok,
    output logic [pli_pkg::BYTE_W-1:0]  removed_byte,
    output logic [pli_pkg::CNT_W-1:0]   count
);

    pli_pkg::ctrl_t ctrl;

    pli_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    pli_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cmd          (cmd),
        .index        (index),
        .byte_in      (byte_in),
        .done         (done),
        .ok           (ok),
        .removed_byte (removed_byte),
        .count        (count)
    );

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200;

    typedef enum int { MODE_FIXED, MODE_FILL, MODE_DRAIN, MODE_MIXED } drive_mode_t;

    typedef struct packed {
        logic                       ok;
        logic [pli_pkg::BYTE_W-1:0] removed;
        logic [pli_pkg::CNT_W-1:0]  count;
    } outcome_t;

    // Mirror of the list contents; every accepted command yields exactly one outcome.
    class list_mirror;
        logic [pli_pkg::BYTE_W-1:0] slots [pli_pkg::CAPACITY];
        int unsigned                entries_held;
        outcome_t                   pending_outcomes[$];
        int unsigned                mismatches;
        int unsigned                results_seen;

        function new();
            entries_held = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void apply_command(logic op, logic [pli_pkg::INDEX_W-1:0] pos,
                                    logic [pli_pkg::BYTE_W-1:0] data);
            outcome_t    o;
            int unsigned k;
            o = '0;
            if (op == pli_pkg::CMD_INSERT)
            begin
                if (entries_held < pli_pkg::CAPACITY && pos <= entries_held)
                begin
                    for (k = entries_held; k > pos; k--)
                        slots[k] = slots[k - 1];
                    slots[pos] = data;
                    entries_held++;
                    o.ok = 1'b1;
                end
            end
            else if (pos < entries_held)
            begin
                o.removed = slots[pos];
                for (k = pos; k + 1 < entries_held; k++)
                    slots[k] = slots[k + 1];
                entries_held--;
                o.ok = 1'b1;
            end
            o.count = pli_pkg::CNT_W'(entries_held);
            pending_outcomes.push_back(o);
        endfunction

        function void compare_outcome(logic ok_v, logic [pli_pkg::BYTE_W-1:0] removed_v,
                                      logic [pli_pkg::CNT_W-1:0] count_v);
            outcome_t want;
            results_seen++;
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with no command outstanding: %s%0b %s%02h %s%0d",
                             results_seen, "ok=", ok_v, "removed=", removed_v,
                             "count=", count_v);
                return;
            end
            want = pending_outcomes.pop_front();
            if (want.ok !== ok_v || want.removed !== removed_v || want.count !== count_v)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected ok=%0b removed=%02h count=%0d, %s",
                             results_seen, want.ok, want.removed, want.count,
                             $sformatf("got ok=%0b removed=%02h count=%0d",
                                       ok_v, removed_v, count_v));
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        cmd = pli_pkg::CMD_INSERT;
    logic [pli_pkg::INDEX_W-1:0] index = '0;
    logic [pli_pkg::BYTE_W-1:0]  byte_in = '0;
    logic                        busy;
    logic                        done;
    logic                        ok;
    logic [pli_pkg::BYTE_W-1:0]  removed_byte;
    logic [pli_pkg::CNT_W-1:0]   count;

    list_mirror board;
    int         gap_max = 14;
    int         stalled_cycles = 0;

    positional_list_insert_delete dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .index        (index),
        .byte_in      (byte_in),
        .done         (done),
        .ok           (ok),
        .removed_byte (removed_byte),
        .count        (count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Outputs are sampled at the rising edge, before the block's own updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.compare_outcome(ok, removed_byte, count);
            if (start && !busy)
                board.apply_command(cmd, index, byte_in);
            if (done || (start && !busy))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("positional_list_insert_delete: mismatch");
                $finish;
            end
        end
    end

    // Fields are chosen after the falling edge, so the mirror already holds
    // every command accepted so far.
    task automatic issue(input drive_mode_t mode, input logic op,
                         input logic [pli_pkg::INDEX_W-1:0] pos,
                         input logic [pli_pkg::BYTE_W-1:0] data);
        int gap;
        int roll;
        int insert_pct;
        gap = $urandom_range(0, gap_max);
        @(negedge clk);
        if (mode != MODE_FIXED)
        begin
            insert_pct = (mode == MODE_FILL) ? 85 : (mode == MODE_DRAIN) ? 15 : 50;
            op   = ($urandom_range(0, 99) < insert_pct) ? pli_pkg::CMD_INSERT
                                                         : pli_pkg::CMD_DELETE;
            data = pli_pkg::BYTE_W'($urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            if (roll < 8)
                pos = pli_pkg::INDEX_W'($urandom_range(0, 127));
            else if (roll < 16)
                pos = pli_pkg::INDEX_W'(board.entries_held);
            else if (roll < 24)
                pos = '0;
            else if (op == pli_pkg::CMD_INSERT)
                pos = pli_pkg::INDEX_W'($urandom_range(0, board.entries_held));
            else if (board.entries_held == 0)
                pos = '0;
            else
                pos = pli_pkg::INDEX_W'($urandom_range(0, board.entries_held - 1));
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd     <= op;
        index   <= pos;
        byte_in <= data;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (board.pending_outcomes.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        board = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Rejections on an empty list, including indexes past the count.
        issue(MODE_FIXED, pli_pkg::CMD_DELETE, 7'd0,   8'h00);
        issue(MODE_FIXED, pli_pkg::CMD_DELETE, 7'd127, 8'hff);
        issue(MODE_FIXED, pli_pkg::CMD_INSERT, 7'd1,   8'h11);
        issue(MODE_FIXED, pli_pkg::CMD_INSERT, 7'd127, 8'h22);
        // Head and tail inserts, then an insert one past the count.
        issue(MODE_FIXED, pli_pkg::CMD_INSERT, 7'd0,   8'h00);
        issue(MODE_FIXED, pli_pkg::CMD_INSERT, 7'd0,   8'hff);
        issue(MODE_FIXED, pli_pkg::CMD_INSERT, 7'd2,   8'ha5);
        issue(MODE_FIXED, pli_pkg::CMD_INSERT, 7'd4,   8'h5a);
        // Delete at index equal to the count must not wrap to the head.
        issue(MODE_FIXED, pli_pkg::CMD_DELETE, 7'd3,   8'h00);
        issue(MODE_FIXED, pli_pkg::CMD_INSERT, 7'd1,   8'h3c);
        issue(MODE_FIXED, pli_pkg::CMD_DELETE, 7'd3,   8'hff);
        issue(MODE_FIXED, pli_pkg::CMD_DELETE, 7'd0,   8'h00);
        issue(MODE_FIXED, pli_pkg::CMD_DELETE, 7'd1,   8'h00);
        issue(MODE_FIXED, pli_pkg::CMD_DELETE, 7'd0,   8'h00);
        issue(MODE_FIXED, pli_pkg::CMD_DELETE, 7'd0,   8'h00);
        wait_drained();

        // Fill phases run the list up to capacity, so inserts into a full
        // list are exercised there; every fourth phase issues back to back.
        for (int p = 0; p < 9; p++)
        begin
            gap_max = (p % 4 == 3) ? 0 : 14;
            for (int n = 0; n < 120; n++)
                issue((p % 3 == 0) ? MODE_FILL : (p % 3 == 1) ? MODE_MIXED : MODE_DRAIN,
                      pli_pkg::CMD_INSERT, '0, '0);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (board.mismatches == 0 && board.pending_outcomes.size() == 0)
            $display("positional_list_insert_delete: match");
        else
            $display("positional_list_insert_delete: mismatch");
        $finish;
    end
endmodule

// ===== positional_list_insert_delete.f =====
hw/rtl/pli_pkg.sv
hw/rtl/pli_ctrl.sv
hw/rtl/pli_dp.sv
hw/rtl/positional_list_insert_delete.sv
tb/tb.sv
